// ===== rtl/i2cm4_pkg.sv =====
// Shared types, codes and phase tables of the four-lane I2C register access master.
package i2cm4_pkg;

   // Item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0] READ_BIT    = 8'h01;
   localparam logic [7:0] TX_MSB_MASK = 8'h80;

   localparam int unsigned SHOWN_LANES = 4;

   typedef enum logic [1:0] {
      SEG_START = 2'd0,
      SEG_STOP  = 2'd1,
      SEG_WR    = 2'd2,
      SEG_RD    = 2'd3
   } seg_kind_type;

   // Byte picks for a write segment
   localparam logic [1:0] SEL_DEV     = 2'd0;
   localparam logic [1:0] SEL_REG     = 2'd1;
   localparam logic [1:0] SEL_VAL     = 2'd2;
   localparam logic [1:0] SEL_DEV_RD  = 2'd3;

   localparam logic [2:0] LAST_SEG_WR = 3'd4;
   localparam logic [2:0] LAST_SEG_RD = 3'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_value;
      logic [3:0] sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] lane0_data;
      logic [7:0] lane1_data;
      logic [7:0] lane2_data;
      logic [7:0] lane3_data;
   } rsp_type;

   typedef struct packed {
      logic       rd;
      logic [7:0] dev;
      logic [7:0] regi;
      logic [7:0] val;
   } cmd_type;

   // Pin and status view of the sequencer after the current transfer
   typedef struct packed {
      logic scl;
      logic sda;
      logic busy;
      logic done;
   } seq_status_type;

   // Commands from the sequencer to the receive lanes
   typedef struct packed {
      logic clear;
      logic shift;
   } lane_ctl_type;

   // Pin operation: is_scl selects the line, level is the value driven
   typedef struct packed {
      logic is_scl;
      logic level;
   } pin_op_type;

   function automatic seg_kind_type plan_kind(input logic rd, input logic [2:0] s);
      seg_kind_type k;
      k = SEG_STOP;
      if (rd) begin
         case (s)
            3'd0, 3'd3:       k = SEG_START;
            3'd1, 3'd2, 3'd4: k = SEG_WR;
            3'd5:             k = SEG_RD;
            default:          k = SEG_STOP;
         endcase
      end else begin
         case (s)
            3'd0:             k = SEG_START;
            3'd1, 3'd2, 3'd3: k = SEG_WR;
            default:          k = SEG_STOP;
         endcase
      end
      return k;
   endfunction

   function automatic logic [1:0] plan_sel(input logic rd, input logic [2:0] s);
      logic [1:0] sel;
      sel = SEL_DEV;
      case (s)
         3'd2:    sel = SEL_REG;
         3'd3:    sel = rd ? SEL_DEV : SEL_VAL;
         3'd4:    sel = rd ? SEL_DEV_RD : SEL_DEV;
         default: sel = SEL_DEV;
      endcase
      return sel;
   endfunction

   function automatic logic [4:0] seg_len(input seg_kind_type k);
      logic [4:0] len;
      len = 5'd6;
      if (k == SEG_WR) len = 5'd29;
      else if (k == SEG_RD) len = 5'd21;
      return len;
   endfunction

   function automatic pin_op_type start_op(input logic [2:0] t);
      pin_op_type op;
      case (t)
         3'd0:    op = '{is_scl: 1'b1, level: 1'b1};
         3'd1:    op = '{is_scl: 1'b0, level: 1'b1};
         3'd2:    op = '{is_scl: 1'b1, level: 1'b1};
         3'd3:    op = '{is_scl: 1'b0, level: 1'b0};
         3'd4:    op = '{is_scl: 1'b1, level: 1'b0};
         default: op = '{is_scl: 1'b0, level: 1'b1};
      endcase
      return op;
   endfunction

   function automatic pin_op_type stop_op(input logic [2:0] t);
      pin_op_type op;
      case (t)
         3'd0:    op = '{is_scl: 1'b1, level: 1'b0};
         3'd1:    op = '{is_scl: 1'b0, level: 1'b0};
         3'd2:    op = '{is_scl: 1'b1, level: 1'b1};
         3'd3:    op = '{is_scl: 1'b0, level: 1'b0};
         3'd4:    op = '{is_scl: 1'b1, level: 1'b1};
         default: op = '{is_scl: 1'b0, level: 1'b1};
      endcase
      return op;
   endfunction

endpackage

// ===== rtl/i2cm4_lane.sv =====
// One receive lane: shift register that collects the read byte of one SDA line.
module i2cm4_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  i2cm4_pkg::lane_ctl_type ctl,
   input  logic                   sda_bit,
   output logic [7:0]             rx_next
);

   logic [7:0] rx_ff;
   logic [7:0] rx_in;

   always_comb begin
      rx_in = rx_ff;
      if (ctl.clear) begin
         rx_in = 8'd0;
      end else if (ctl.shift) begin
         rx_in = {rx_ff[6:0], sda_bit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff <= 8'd0;
      end else begin
         rx_ff <= rx_in;
      end
   end

   assign rx_next = rx_in;

endmodule

// ===== rtl/i2cm4_seq.sv =====
// Phase sequencer: tick divider, segment/offset counters, transmit shifter and pin levels.
module i2cm4_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  i2cm4_pkg::req_type        req,
   input  logic [15:0]               step_ticks,
   output i2cm4_pkg::seq_status_type status,
   output i2cm4_pkg::lane_ctl_type   lane_ctl
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type               state_ff, state_in;
   i2cm4_pkg::cmd_type      cmd_ff, cmd_in;
   logic [2:0]              seg_ff, seg_in;
   logic [4:0]              t_ff, t_in;
   logic [1:0]              sub_ff, sub_in;
   logic [15:0]             div_ff, div_in;
   logic [7:0]              tx_ff, tx_in;
   logic                    scl_ff, scl_in;
   logic                    sda_ff, sda_in;

   i2cm4_pkg::seg_kind_type seg_kind;
   logic [1:0]              seg_sel;
   logic [4:0]              len;
   logic [2:0]              last_seg;
   logic [15:0]             lim;
   logic [16:0]             nd;
   logic                    step_en;
   logic                    done;
   logic [7:0]              pick;
   i2cm4_pkg::pin_op_type   op;

   assign seg_kind = i2cm4_pkg::plan_kind(cmd_ff.rd, seg_ff);
   assign seg_sel  = i2cm4_pkg::plan_sel(cmd_ff.rd, seg_ff);
   assign len      = i2cm4_pkg::seg_len(seg_kind);
   assign last_seg = cmd_ff.rd ? i2cm4_pkg::LAST_SEG_RD : i2cm4_pkg::LAST_SEG_WR;
   assign lim      = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
   assign nd       = {1'b0, div_ff} + 17'd1;

   always_comb begin
      unique case (seg_sel)
         i2cm4_pkg::SEL_DEV:    pick = cmd_ff.dev;
         i2cm4_pkg::SEL_REG:    pick = cmd_ff.regi;
         i2cm4_pkg::SEL_VAL:    pick = cmd_ff.val;
         i2cm4_pkg::SEL_DEV_RD: pick = cmd_ff.dev | i2cm4_pkg::READ_BIT;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      seg_in   = seg_ff;
      t_in     = t_ff;
      sub_in   = sub_ff;
      div_in   = div_ff;
      tx_in    = tx_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      step_en  = 1'b0;
      done     = 1'b0;
      lane_ctl = '0;
      op       = '0;

      // Divider: a command while busy is dropped and does not count as a tick
      if (fire) begin
         if (state_ff == ST_IDLE) begin
            if (req.kind == i2cm4_pkg::KIND_WRITE || req.kind == i2cm4_pkg::KIND_READ) begin
               cmd_in   = '{rd: (req.kind == i2cm4_pkg::KIND_READ), dev: req.device_address,
                            regi: req.register_address, val: req.write_value};
               state_in = ST_RUN;
               div_in   = 16'd0;
               seg_in   = 3'd0;
               t_in     = 5'd0;
               sub_in   = 2'd0;
            end
         end else if (req.kind == i2cm4_pkg::KIND_TICK) begin
            if (nd >= {1'b0, lim}) begin
               div_in  = 16'd0;
               step_en = 1'b1;
            end else begin
               div_in = nd[15:0];
            end
         end
      end

      if (step_en) begin
         unique case (seg_kind)
            i2cm4_pkg::SEG_START, i2cm4_pkg::SEG_STOP: begin
               op = (seg_kind == i2cm4_pkg::SEG_START) ? i2cm4_pkg::start_op(t_ff[2:0])
                                                       : i2cm4_pkg::stop_op(t_ff[2:0]);
               if (op.is_scl) scl_in = op.level;
               else sda_in = op.level;
            end
            i2cm4_pkg::SEG_WR: begin
               if (t_ff < 5'd24) begin
                  unique case (sub_ff)
                     2'd0:    scl_in = 1'b0;
                     2'd1:    sda_in = (tx_ff & i2cm4_pkg::TX_MSB_MASK) != 8'd0;
                     default: begin
                        scl_in = 1'b1;
                        tx_in  = {tx_ff[6:0], 1'b0};
                     end
                  endcase
                  // load the byte on the first phase of the segment
                  if (t_ff == 5'd0) tx_in = pick;
               end else if (t_ff == 5'd24 || t_ff == 5'd27) begin
                  scl_in = 1'b0;
               end else if (t_ff == 5'd25) begin
                  sda_in = 1'b1;
               end else if (t_ff == 5'd26) begin
                  scl_in = 1'b1;
               end
            end
            i2cm4_pkg::SEG_RD: begin
               if (t_ff == 5'd0) begin
                  lane_ctl.clear = 1'b1;
                  scl_in         = 1'b0;
               end else if (t_ff == 5'd1) begin
                  sda_in = 1'b1;
               end else if (t_ff < 5'd18) begin
                  if (!t_ff[0]) begin
                     scl_in = 1'b1;
                  end else begin
                     lane_ctl.shift = 1'b1;
                     scl_in         = 1'b0;
                  end
               end else if (t_ff == 5'd18) begin
                  scl_in = 1'b1;
               end else if (t_ff == 5'd19) begin
                  scl_in = 1'b0;
               end
            end
         endcase

         // Advance the phase counters
         if (t_ff == len - 5'd1) begin
            if (seg_ff == last_seg) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               seg_in = seg_ff + 3'd1;
            end
            t_in   = 5'd0;
            sub_in = 2'd0;
         end else begin
            t_in   = t_ff + 5'd1;
            sub_in = (sub_ff == 2'd2) ? 2'd0 : sub_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= '0;
         seg_ff   <= 3'd0;
         t_ff     <= 5'd0;
         sub_ff   <= 2'd0;
         div_ff   <= 16'd0;
         tx_ff    <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         seg_ff   <= seg_in;
         t_ff     <= t_in;
         sub_ff   <= sub_in;
         div_ff   <= div_in;
         tx_ff    <= tx_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
      end
   end

   assign status = '{scl: scl_in, sda: sda_in, busy: (state_in == ST_RUN), done: done};

endmodule

// ===== rtl/i2c_master_four_lane_register_access.sv =====
// Top level: four-lane I2C register access master with APB register port and result buffer.
// Results: each transfer's result enters the result buffer at its acceptance edge and is
//   offered on rsp_valid in the next cycle at the earliest, behind any result still waiting.
// Throughput: one transfer per cycle while req_ready is high; a phase per step_ticks ticks.
// A two-entry result buffer keeps req_ready high while one result waits for the consumer.
// Reset (synchronous): idle, pins high, receive lanes zero, step_ticks 1, buffer empty.
module i2c_master_four_lane_register_access #(
   parameter int unsigned LANES = 4
) (
   input  logic                clock,
   input  logic                reset,
   // input channel
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cm4_pkg::req_type  req_data,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cm4_pkg::rsp_type  rsp_data,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int unsigned DEPTH = 2;

   logic [15:0] step_ff, step_in;

   logic                      fire;
   logic                      pop;
   i2cm4_pkg::seq_status_type status;
   i2cm4_pkg::lane_ctl_type   lane_ctl;
   logic [7:0]                rx_next [LANES];
   logic [7:0]                shown   [i2cm4_pkg::SHOWN_LANES];
   i2cm4_pkg::rsp_type        result;

   i2cm4_pkg::rsp_type buf_ff [DEPTH];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   // Register port: step_ticks at addresses 0 to 3 (paddr[2] low), written on the access cycle
   assign pready = 1'b1;

   always_comb begin
      step_in = step_ff;
      if (psel && penable && pwrite && pready && !paddr[2]) begin
         step_in = pwdata[15:0];
      end
   end

   assign prdata = paddr[2] ? 32'd0 : {16'd0, step_ff};

   // Input handshake: hold off only while the result buffer is full
   assign req_ready = (count_ff != 2'd2);
   assign fire      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   i2cm4_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .req        (req_data),
      .step_ticks (step_ff),
      .status     (status),
      .lane_ctl   (lane_ctl)
   );

   // Receive lanes work side by side on the sampled SDA bits; lanes past the
   // four sampled lines shift in zero
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic sda_bit;
      if (j < i2cm4_pkg::SHOWN_LANES) begin : g_wired
         assign sda_bit = req_data.sda_sample[j];
      end else begin : g_unwired
         assign sda_bit = 1'b0;
      end
      i2cm4_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (lane_ctl),
         .sda_bit (sda_bit),
         .rx_next (rx_next[j])
      );
   end

   // Merge: gather lane bytes into the result; missing lanes read as zero
   for (genvar j = 0; j < i2cm4_pkg::SHOWN_LANES; j++) begin : g_merge
      if (j < LANES) begin : g_have
         assign shown[j] = rx_next[j];
      end else begin : g_none
         assign shown[j] = 8'd0;
      end
   end

   assign result = '{scl_level: status.scl, sda_release: status.sda,
                     busy_res: status.busy, done_res: status.done,
                     lane0_data: shown[0], lane1_data: shown[1],
                     lane2_data: shown[2], lane3_data: shown[3]};

   // Result buffer: every accepted transfer produces exactly one result
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (fire) wr_ptr_in = ~wr_ptr_ff;
      if (pop)  rd_ptr_in = ~rd_ptr_ff;
      if (fire && !pop) count_in = count_ff + 2'd1;
      else if (!fire && pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         buf_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= 16'd1;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         step_ff   <= step_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = buf_ff[rd_ptr_ff];

endmodule

// ===== rtl/i2cm4_checker.sv =====
// Port-level checker for the four-lane I2C register access master, with its bind.
module i2cm4_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input i2cm4_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input i2cm4_pkg::rsp_type rsp_data,
   input logic               psel,
   input logic               penable,
   input logic               pwrite,
   input logic [2:0]         paddr,
   input logic [31:0]        pwdata,
   input logic [31:0]        prdata,
   input logic               pready
);

   // Buffer is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Input back-pressure only while results wait
   a_ready_skid: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // The stop step ends the transaction
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res && rsp_data.scl_level
                                          && rsp_data.sda_release)
      else $error("done with transaction still open or lines low");

endmodule

bind i2c_master_four_lane_register_access i2cm4_checker u_i2cm4_checker (.*);

// ===== tb/i2c_sequence_checker.sv =====
// Checker for the four-lane I2C master: predicts every result and compares it with the block.
module i2c_sequence_checker #(
   parameter logic [2:0] STEP_ADDR = 3'd0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  i2cm4_pkg::req_type  req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  i2cm4_pkg::rsp_type  rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   input  logic                pready,
   output int unsigned         fail_count,
   output int unsigned         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_REPORTS = 10;

   // Predicted sequencer state
   logic [6:0]         phase_q;
   logic [15:0]        step_cfg;
   logic [15:0]        tick_count;
   logic [7:0]         tx_byte;
   logic [7:0]         rx_byte [i2cm4_pkg::SHOWN_LANES];
   i2cm4_pkg::cmd_type held;
   logic               scl_q;
   logic               sda_q;

   i2cm4_pkg::rsp_type expected_pins [$];
   int unsigned        reports;

   function automatic void start_cond(input int unsigned t);
      case (t)
         0:       scl_q = 1'b1;
         1:       sda_q = 1'b1;
         2:       scl_q = 1'b1;
         3:       sda_q = 1'b0;
         4:       scl_q = 1'b0;
         default: sda_q = 1'b1;
      endcase
   endfunction

   function automatic void stop_cond(input int unsigned t);
      case (t)
         0:       scl_q = 1'b0;
         1:       sda_q = 1'b0;
         2:       scl_q = 1'b1;
         3:       sda_q = 1'b0;
         4:       scl_q = 1'b1;
         default: sda_q = 1'b1;
      endcase
   endfunction

   // One phase of a byte sent MSB first, then the clocked acknowledge and a trailing delay
   function automatic void send_byte(input int unsigned t, input logic [7:0] value);
      if (t < 24) begin
         if (t == 0) tx_byte = value;
         case (t % 3)
            0:       scl_q = 1'b0;
            1:       sda_q = tx_byte[7];
            default: begin
               scl_q = 1'b1;
               tx_byte = tx_byte << 1;
            end
         endcase
      end else if (t == 24 || t == 27) begin
         scl_q = 1'b0;
      end else if (t == 25) begin
         sda_q = 1'b1;
      end else if (t == 26) begin
         scl_q = 1'b1;
      end
   endfunction

   // One phase of the read byte: clear, release, eight bits sampled on SCL fall, no ack
   function automatic void receive_byte(input int unsigned t, input logic [3:0] sample);
      int unsigned q;
      if (t == 0) begin
         for (int j = 0; j < i2cm4_pkg::SHOWN_LANES; j++) rx_byte[j] = '0;
         scl_q = 1'b0;
      end else if (t == 1) begin
         sda_q = 1'b1;
      end else if (t < 18) begin
         q = t - 2;
         if (q % 2 == 0) begin
            scl_q = 1'b1;
         end else begin
            for (int j = 0; j < i2cm4_pkg::SHOWN_LANES; j++)
               rx_byte[j] = {rx_byte[j][6:0], sample[j]};
            scl_q = 1'b0;
         end
      end else if (t == 18) begin
         scl_q = 1'b1;
      end else if (t == 19) begin
         scl_q = 1'b0;
      end
   endfunction

   // Execute phase p (from 1); return high on the last phase of the transaction
   function automatic logic run_bus_phase(input logic [6:0] p, input logic [3:0] sample);
      int unsigned t;
      t = p - 1;
      if (!held.rd) begin
         if (t < 6) start_cond(t);
         else if (t < 93)
            send_byte((t - 6) % 29, ((t - 6) / 29 == 0) ? held.dev :
                                    ((t - 6) / 29 == 1) ? held.regi : held.val);
         else stop_cond(t - 93);
         return t == 98;
      end
      if (t < 6) start_cond(t);
      else if (t < 64) send_byte((t - 6) % 29, ((t - 6) / 29 == 0) ? held.dev : held.regi);
      else if (t < 70) start_cond(t - 64);
      else if (t < 99) send_byte(t - 70, held.dev | i2cm4_pkg::READ_BIT);
      else if (t < 120) receive_byte(t - 99, sample);
      else stop_cond(t - 120);
      return t == 125;
   endfunction

   function automatic i2cm4_pkg::rsp_type step_bus_sequencer(input i2cm4_pkg::req_type item);
      i2cm4_pkg::rsp_type r;
      logic               finished;
      int unsigned        limit;
      finished = 1'b0;
      if (phase_q == '0) begin
         if (item.kind == i2cm4_pkg::KIND_WRITE || item.kind == i2cm4_pkg::KIND_READ) begin
            held.rd   = (item.kind == i2cm4_pkg::KIND_READ);
            held.dev  = item.device_address;
            held.regi = item.register_address;
            held.val  = item.write_value;
            phase_q    = 7'd1;
            tick_count = '0;
         end
      end else if (item.kind == i2cm4_pkg::KIND_TICK) begin
         limit = (step_cfg == '0) ? 1 : step_cfg;
         if (32'(tick_count) + 1 >= limit) begin
            tick_count = '0;
            finished = run_bus_phase(phase_q, item.sda_sample);
            phase_q = finished ? 7'd0 : phase_q + 7'd1;
         end else begin
            tick_count = tick_count + 16'd1;
         end
      end
      r.scl_level   = scl_q;
      r.sda_release = sda_q;
      r.busy_res    = (phase_q != '0);
      r.done_res    = finished;
      r.lane0_data  = rx_byte[0];
      r.lane1_data  = rx_byte[1];
      r.lane2_data  = rx_byte[2];
      r.lane3_data  = rx_byte[3];
      return r;
   endfunction

   always @(posedge clock) begin
      i2cm4_pkg::rsp_type want;
      if (reset) begin
         phase_q    = '0;
         step_cfg   = 16'd1;
         tick_count = '0;
         tx_byte    = '0;
         for (int j = 0; j < i2cm4_pkg::SHOWN_LANES; j++) rx_byte[j] = '0;
         held       = '0;
         scl_q      = 1'b1;
         sda_q      = 1'b1;
         expected_pins.delete();
         reports    = 0;
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == STEP_ADDR)
            step_cfg = pwdata[15:0];
         if (req_valid && req_ready)
            expected_pins.push_back(step_bus_sequencer(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_pins.size() == 0) begin
               fail_count++;
               if (reports < MAX_REPORTS) begin
                  reports++;
                  $display("%0t: result with nothing expected: %h", $realtime, rsp_data);
               end
            end else begin
               want = expected_pins.pop_front();
               if (rsp_data.scl_level !== want.scl_level
                   || rsp_data.sda_release !== want.sda_release
                   || rsp_data.busy_res !== want.busy_res
                   || rsp_data.done_res !== want.done_res
                   || rsp_data.lane0_data !== want.lane0_data
                   || rsp_data.lane1_data !== want.lane1_data
                   || rsp_data.lane2_data !== want.lane2_data
                   || rsp_data.lane3_data !== want.lane3_data) begin
                  fail_count++;
                  if (reports < MAX_REPORTS) begin
                     reports++;
                     $display("%0t: mismatch scl/sda/busy/done/lanes expected %b%b%b%b %h %h %h %h",
                              $realtime, want.scl_level, want.sda_release, want.busy_res,
                              want.done_res, want.lane0_data, want.lane1_data,
                              want.lane2_data, want.lane3_data);
                     $display("%0t:                                  actual %b%b%b%b %h %h %h %h",
                              $realtime, rsp_data.scl_level, rsp_data.sda_release,
                              rsp_data.busy_res, rsp_data.done_res, rsp_data.lane0_data,
                              rsp_data.lane1_data, rsp_data.lane2_data, rsp_data.lane3_data);
                  end
               end
            end
         end
      end
      pending = expected_pins.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench: clock, reset, stimulus and verdict for the four-lane I2C master.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0]  STEP_TICKS_ADDR = 3'd0;   // step_ticks register
   localparam logic [1:0]  KIND_UNUSED     = 2'd3;   // kind code with no meaning
   localparam int unsigned WRITE_PHASES    = 99;
   localparam int unsigned READ_PHASES     = 126;
   localparam int unsigned ITEMS_PER_MODE  = 100;
   localparam int unsigned STEP_MAX        = 65535;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   i2cm4_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   i2cm4_pkg::rsp_type rsp_data;
   logic               psel      = 1'b0;
   logic               penable   = 1'b0;
   logic               pwrite    = 1'b0;
   logic [2:0]         paddr     = '0;
   logic [31:0]        pwdata    = '0;
   logic [31:0]        prdata;
   logic               pready;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent     = 0;
   logic [15:0] step_now       = 16'd1;   // step_ticks as last written, reset value 1

   always #5 clock = ~clock;

   i2c_master_four_lane_register_access dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   i2c_sequence_checker #(.STEP_ADDR(STEP_TICKS_ADDR)) bus_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Stall the result channel at random; the rate follows the current idling phase
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Hard stop in case the block hangs or drops results
   initial begin
      #1ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic i2cm4_pkg::req_type make_item(input logic [1:0] kind,
                                                    input logic [7:0] dev,
                                                    input logic [7:0] regi,
                                                    input logic [7:0] val,
                                                    input logic [3:0] sda);
      i2cm4_pkg::req_type item;
      item.kind             = kind;
      item.device_address   = dev;
      item.register_address = regi;
      item.write_value      = val;
      item.sda_sample       = sda;
      return item;
   endfunction

   // Command or meaningless kind dropped into a transaction: the block must ignore it
   function automatic i2cm4_pkg::req_type stray_item();
      logic [1:0] kind;
      case ($urandom_range(2))
         0:       kind = i2cm4_pkg::KIND_WRITE;
         1:       kind = i2cm4_pkg::KIND_READ;
         default: kind = KIND_UNUSED;
      endcase
      return make_item(kind, 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
   endfunction

   // Ticks that carry a transaction from its command to the end of its stop condition
   function automatic int unsigned access_ticks(input logic [1:0] kind);
      return ((kind == i2cm4_pkg::KIND_READ) ? READ_PHASES : WRITE_PHASES) *
             ((step_now == '0) ? 1 : step_now);
   endfunction

   // Hold the sender idle at random, then present the item and hold it until the transfer
   task automatic send_item(input i2cm4_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Write step_ticks through the register port; only while the block is idle
   task automatic write_step_ticks(input logic [15:0] value);
      drain();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= STEP_TICKS_ADDR;
      pwdata  <= {16'($urandom), value};   // upper bits are not part of the register
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      step_now = value;
   endtask

   // One register access: the command, then its ticks with stray items mixed in
   task automatic run_access(input logic [1:0] kind, input logic [7:0] dev,
                             input logic [7:0] regi, input logic [7:0] val,
                             input bit sda_random, input logic [3:0] sda_level,
                             input int unsigned ticks, input int unsigned stray_pct,
                             input bit pause_midway);
      int unsigned sent;
      logic [3:0]  sda;
      send_item(make_item(kind, dev, regi, val, 4'($urandom)));
      sent = 0;
      while (sent < ticks) begin
         if ($urandom_range(99) < stray_pct) begin
            send_item(stray_item());
         end else begin
            sda = sda_random ? 4'($urandom) : sda_level;
            send_item(make_item(i2cm4_pkg::KIND_TICK, 8'($urandom), 8'($urandom),
                                8'($urandom), sda));
            sent++;
            if (pause_midway && sent == ticks / 2) drain();
         end
      end
   endtask

   initial begin : stimulus
      int unsigned mode_start;
      logic [1:0]  kind;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: idle ticks and junk do nothing, field extremes, lanes all ones and
      // all zeros, a write that must leave the lanes alone, a read that clears them
      send_item(make_item(i2cm4_pkg::KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 4'hF));
      send_item(make_item(KIND_UNUSED, 8'h00, 8'h00, 8'h00, 4'h0));
      run_access(i2cm4_pkg::KIND_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b0, 4'hF,
                 access_ticks(i2cm4_pkg::KIND_WRITE), 10, 1'b0);
      run_access(i2cm4_pkg::KIND_READ, 8'h00, 8'h00, 8'h00, 1'b0, 4'hF,
                 access_ticks(i2cm4_pkg::KIND_READ), 10, 1'b0);
      run_access(i2cm4_pkg::KIND_WRITE, 8'h00, 8'h00, 8'h00, 1'b0, 4'h0,
                 access_ticks(i2cm4_pkg::KIND_WRITE), 0, 1'b0);
      run_access(i2cm4_pkg::KIND_READ, 8'hFF, 8'hFF, 8'hFF, 1'b0, 4'h0,
                 access_ticks(i2cm4_pkg::KIND_READ), 10, 1'b0);

      // Random: one idling phase per pass; the passes use step settings 0, 2, 1 and 1.
      // A step of zero must act as one.
      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               write_step_ticks(16'd0);
            end
            1: begin
               send_idle_pct  = 88;
               recv_stall_pct = 0;
               write_step_ticks(16'd2);
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 88;
               write_step_ticks(16'd1);
            end
            default: begin
               send_idle_pct  = 17;
               recv_stall_pct = 17;
               write_step_ticks(16'd1);
            end
         endcase
         mode_start = items_sent;
         while (items_sent - mode_start < ITEMS_PER_MODE) begin
            kind = $urandom_range(1) ? i2cm4_pkg::KIND_READ : i2cm4_pkg::KIND_WRITE;
            // Under heavy receiver stall, pause once mid-transaction until all results are in
            run_access(kind, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 4'h0,
                       access_ticks(kind), 5, mode == 2 && items_sent == mode_start);
            // Idle ticks and junk between transactions
            repeat ($urandom_range(3))
               send_item(make_item($urandom_range(1) ? i2cm4_pkg::KIND_TICK : KIND_UNUSED,
                                   8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom)));
         end
      end

      // Largest step: the divider counts every tick, but no phase comes due within the run
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_step_ticks(16'(STEP_MAX));
      run_access(i2cm4_pkg::KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 4'h0,
                 40, 0, 1'b0);

      // Advance until nothing is outstanding, let the result buffer settle, then judge
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
